[rtl/fbsc_pkg.sv]
// ----------------------------------------------------------------------------
// fbsc_pkg
// shared types, field widths, codes and helpers of the frame store scroller
// ----------------------------------------------------------------------------
package fbsc_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_PIXEL_BITS = 32;

	localparam int DIM_W     = 9;
	localparam int COORD_W   = 8;
	localparam int VALUE_W   = 32;
	localparam int ACTION_W  = 2;
	localparam int STATUS_W  = 2;
	localparam int SHIFT_W   = 9;
	localparam int CFG_IDX_W = 2;
	localparam int DIM_RESET = 256;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE  = 2'd0,
		ACT_READ   = 2'd1,
		ACT_SCROLL = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_ZERO  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// operand choice of the shared multiply-add
	typedef enum logic [1:0] {
		MA_PIX  = 2'd0,
		MA_OFF  = 2'd1,
		MA_LAST = 2'd2
	} madd_sel_t;

	typedef struct packed {
		logic      load;
		logic      madd_en;
		madd_sel_t madd_sel;
		logic      off_load;
		logic      scan_init;
		logic      scan_step;
		logic      pix_wr;
		logic      pix_rd;
		logic      out_load;
	} fbsc_cmd_t;

	typedef struct packed {
		action_t action;
		logic    pix_oob;
		logic    zero_mv;
		logic    off_oob;
		logic    scan_last;
	} fbsc_stat_t;

	// zero reads as one, anything above the maximum reads as the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input int unsigned maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (32'(v) > maxv)
			r = DIM_W'(maxv);
		return r;
	endfunction

endpackage

[rtl/fbsc_if.sv]
// ----------------------------------------------------------------------------
// fbsc channel interfaces
// item, result and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface fbsc_item_if import fbsc_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [ACTION_W-1:0]       action;
	logic [COORD_W-1:0]        pixel_x;
	logic [COORD_W-1:0]        pixel_y;
	logic [VALUE_W-1:0]        pixel_value;
	logic signed [SHIFT_W-1:0] shift_down;
	logic signed [SHIFT_W-1:0] shift_right;

	modport source (output valid, action, pixel_x, pixel_y, pixel_value,
		shift_down, shift_right, input ready);
	modport sink (input valid, action, pixel_x, pixel_y, pixel_value,
		shift_down, shift_right, output ready);
endinterface

interface fbsc_result_if import fbsc_pkg::*;;
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  read_value;
	logic [STATUS_W-1:0] status;

	modport source (output valid, read_value, status, input ready);
	modport sink (input valid, read_value, status, output ready);
endinterface

interface fbsc_cfg_if import fbsc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/fbsc_ram.sv]
// ----------------------------------------------------------------------------
// fbsc_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fbsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[rtl/fbsc_ctrl.sv]
// ----------------------------------------------------------------------------
// fbsc_ctrl
// sequencing state machine and result handshake of the frame store scroller
// ----------------------------------------------------------------------------
module fbsc_ctrl import fbsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	output logic       res_valid,
	input  logic       res_ready,
	input  fbsc_stat_t stat,
	output fbsc_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_PIX,
		S_SC_OFF,
		S_SC_INIT,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q, nxt;
	logic   out_valid_q;

	always_comb begin
		cmd        = '0;
		nxt        = state_q;
		item_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					nxt      = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.madd_en  = 1'b1;
				cmd.madd_sel = (stat.action == ACT_SCROLL) ? MA_OFF : MA_PIX;
				unique case (stat.action)
					ACT_WRITE, ACT_READ: nxt = stat.pix_oob ? S_FINISH : S_PIX;
					ACT_SCROLL: nxt = (stat.zero_mv || stat.off_oob) ? S_FINISH : S_SC_OFF;
					ACT_NONE: nxt = S_FINISH;
				endcase
			end
			S_PIX: begin
				cmd.pix_wr = (stat.action == ACT_WRITE);
				cmd.pix_rd = (stat.action == ACT_READ);
				nxt        = S_FINISH;
			end
			S_SC_OFF: begin
				cmd.off_load = 1'b1;
				cmd.madd_en  = 1'b1;
				cmd.madd_sel = MA_LAST;
				nxt          = S_SC_INIT;
			end
			S_SC_INIT: begin
				cmd.scan_init = 1'b1;
				nxt           = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last)
					nxt = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || res_ready) begin
					cmd.out_load = 1'b1;
					nxt          = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || res_ready))
		else $error("result word overwritten before it was taken");

	a_pix_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PIX) |-> ((stat.action == ACT_WRITE || stat.action == ACT_READ)
		&& !stat.pix_oob))
		else $error("pixel access started for an illegal item");

	a_scroll_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SC_OFF) |-> (stat.action == ACT_SCROLL && !stat.zero_mv
		&& !stat.off_oob))
		else $error("scroll started for a rejected offset");

endmodule

[rtl/fbsc_dp.sv]
// ----------------------------------------------------------------------------
// fbsc_dp
// registers, address arithmetic, scan counters and frame store of the scroller
// ----------------------------------------------------------------------------
module fbsc_dp import fbsc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [DIM_W-1:0]          cfg_data,
	input  logic [ACTION_W-1:0]       action,
	input  logic [COORD_W-1:0]        pixel_x,
	input  logic [COORD_W-1:0]        pixel_y,
	input  logic [VALUE_W-1:0]        pixel_value,
	input  logic signed [SHIFT_W-1:0] shift_down,
	input  logic signed [SHIFT_W-1:0] shift_right,
	input  fbsc_cmd_t                 cmd,
	output fbsc_stat_t                stat,
	output logic [VALUE_W-1:0]        read_value,
	output logic [STATUS_W-1:0]       status
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int LIN_W = 2 * DIM_W + 2;
	localparam int XS_W  = DIM_W + 2;
	localparam int AB_W  = DIM_W + 1;

	logic [DIM_W-1:0]          width_q, height_q;
	action_t                   act_q;
	logic [COORD_W-1:0]        px_q, py_q;
	logic [PIXEL_BITS-1:0]     val_q;
	logic signed [SHIFT_W-1:0] dy_q, dx_q;
	logic signed [LIN_W-1:0]   madd_q, off_q, dst_q;
	logic [DIM_W-1:0]          x_q, y_q;
	logic                      fwd_q;
	logic                      wr_pend_s1;
	logic [AW-1:0]             wr_addr_s1;
	logic [VALUE_W-1:0]        rv_q;
	status_t                   st_q, st_code;

	logic signed [LIN_W-1:0]   ma_a, ma_b, ma_sum, src_lin;
	logic signed [XS_W-1:0]    sx, sy;
	logic signed [AB_W-1:0]    dx_ext, dy_ext;
	logic [AB_W-1:0]           adx, ady;
	logic                      pix_oob, zero_mv, off_oob, fwd, src_ok, scan_last;
	logic                      ram_we, ram_re;
	logic [AW-1:0]             ram_waddr, ram_raddr, src_addr;
	logic [PIXEL_BITS-1:0]     ram_wdata, ram_rdata;

	// register file, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= clamp_dim(DIM_W'(DIM_RESET), MAX_WIDTH);
			height_q <= clamp_dim(DIM_W'(DIM_RESET), MAX_HEIGHT);
		end else if (cfg_we) begin
			if (cfg_index == CFG_WIDTH)
				width_q <= clamp_dim(cfg_data, MAX_WIDTH);
			else if (cfg_index == CFG_HEIGHT)
				height_q <= clamp_dim(cfg_data, MAX_HEIGHT);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action_t'(action);
			px_q  <= pixel_x;
			py_q  <= pixel_y;
			val_q <= PIXEL_BITS'(pixel_value);
			dy_q  <= shift_down;
			dx_q  <= shift_right;
		end
	end

	// item checks
	assign dx_ext  = AB_W'(dx_q);
	assign dy_ext  = AB_W'(dy_q);
	assign adx     = dx_q[SHIFT_W-1] ? AB_W'(-dx_ext) : AB_W'(dx_ext);
	assign ady     = dy_q[SHIFT_W-1] ? AB_W'(-dy_ext) : AB_W'(dy_ext);
	assign pix_oob = (DIM_W'(px_q) >= width_q) || (DIM_W'(py_q) >= height_q);
	assign zero_mv = (dx_q == '0) && (dy_q == '0);
	assign off_oob = (adx >= AB_W'(width_q)) || (ady >= AB_W'(height_q));
	assign fwd     = dy_q[SHIFT_W-1] || ((dy_q == '0) && dx_q[SHIFT_W-1]);

	// shared multiply-add: a * width + b
	always_comb begin
		unique case (cmd.madd_sel)
			MA_PIX: begin
				ma_a = $signed(LIN_W'(py_q));
				ma_b = $signed(LIN_W'(px_q));
			end
			MA_OFF: begin
				ma_a = LIN_W'(dy_q);
				ma_b = LIN_W'(dx_q);
			end
			MA_LAST: begin
				ma_a = $signed(LIN_W'(height_q - DIM_W'(1)));
				ma_b = $signed(LIN_W'(width_q - DIM_W'(1)));
			end
			default: begin
				ma_a = '0;
				ma_b = '0;
			end
		endcase
	end

	assign ma_sum = (ma_a * $signed(LIN_W'(width_q))) + ma_b;

	always_ff @(posedge clk) begin
		if (cmd.madd_en)
			madd_q <= ma_sum;
		if (cmd.off_load)
			off_q <= madd_q;
	end

	// scan walk over the frame
	assign sx        = $signed(XS_W'(x_q)) - XS_W'(dx_q);
	assign sy        = $signed(XS_W'(y_q)) - XS_W'(dy_q);
	assign src_ok    = !sx[XS_W-1] && !sy[XS_W-1] && (sx < $signed(XS_W'(width_q)))
		&& (sy < $signed(XS_W'(height_q)));
	assign src_lin   = dst_q - off_q;
	assign src_addr  = AW'(src_lin);
	assign scan_last = fwd_q ? ((x_q == width_q - DIM_W'(1)) && (y_q == height_q - DIM_W'(1)))
		: ((x_q == '0) && (y_q == '0));

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			fwd_q <= fwd;
			if (fwd) begin
				x_q   <= '0;
				y_q   <= '0;
				dst_q <= '0;
			end else begin
				x_q   <= width_q - DIM_W'(1);
				y_q   <= height_q - DIM_W'(1);
				dst_q <= madd_q;
			end
		end else if (cmd.scan_step) begin
			if (fwd_q) begin
				dst_q <= dst_q + LIN_W'(1);
				if (x_q == width_q - DIM_W'(1)) begin
					x_q <= '0;
					y_q <= y_q + DIM_W'(1);
				end else begin
					x_q <= x_q + DIM_W'(1);
				end
			end else begin
				dst_q <= dst_q - LIN_W'(1);
				if (x_q == '0) begin
					x_q <= width_q - DIM_W'(1);
					y_q <= y_q - DIM_W'(1);
				end else begin
					x_q <= x_q - DIM_W'(1);
				end
			end
		end
	end

	// copy write follows in the cycle after its source read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wr_pend_s1 <= 1'b0;
		else
			wr_pend_s1 <= cmd.scan_step && src_ok;
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step)
			wr_addr_s1 <= AW'(dst_q);
	end

	assign ram_we    = cmd.pix_wr || wr_pend_s1;
	assign ram_waddr = wr_pend_s1 ? wr_addr_s1 : AW'(madd_q);
	assign ram_wdata = wr_pend_s1 ? ram_rdata : val_q;
	assign ram_re    = cmd.pix_rd || (cmd.scan_step && src_ok);
	assign ram_raddr = cmd.scan_step ? src_addr : AW'(madd_q);

	fbsc_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result word
	always_comb begin
		unique case (act_q)
			ACT_WRITE, ACT_READ: st_code = pix_oob ? ST_RANGE : ST_DONE;
			ACT_SCROLL: st_code = zero_mv ? ST_ZERO : (off_oob ? ST_RANGE : ST_DONE);
			ACT_NONE: st_code = ST_DONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			st_q <= st_code;
			rv_q <= ((act_q == ACT_READ) && !pix_oob) ? VALUE_W'(ram_rdata) : '0;
		end
	end

	assign read_value     = rv_q;
	assign status         = st_q;
	assign stat.action    = act_q;
	assign stat.pix_oob   = pix_oob;
	assign stat.zero_mv   = zero_mv;
	assign stat.off_oob   = off_oob;
	assign stat.scan_last = scan_last;

	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && src_ok && wr_pend_s1) |-> (src_addr != wr_addr_s1))
		else $error("copy source read while it is being written");

	a_scan_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> ((x_q < width_q) && (y_q < height_q)))
		else $error("scan position left the active frame");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> (!cmd.pix_wr && !cmd.pix_rd))
		else $error("pixel access collides with a copy write");

endmodule

[rtl/framebuffer_scroll_copy.sv]
// ----------------------------------------------------------------------------
// framebuffer_scroll_copy
// frame store with pixel write, pixel read and in-place scroll
// ----------------------------------------------------------------------------
// channels
//   item   : one word per operation: write pixel, read pixel or scroll by a
//            signed (shift_down, shift_right) offset
//   result : one word per item, read_value (zero unless an in-range pixel read) and status
//   cfg    : register writes, index 0 active width, index 1 active height;
//            always ready, to be used only while no item is in flight
// steps after an item is taken
//   pixel write or read : decode, store access, then the result is loaded
//   rejected item       : decode, then the result is loaded (zero
//                         movement, offset or pixel out of range)
//   scroll              : decode, offset, scan start, one pixel a cycle over
//                         width * height pixels through the single read and
//                         single write port of the store, then the result;
// the next item is taken only after that. The result sits in an output register, so an item is taken while the
// previous word still waits; a stalled receiver only holds the block at the
// end of the following item
// reset clears the controller and sets width and height to 256 (clamped to
// the frame maximum); the store itself is not cleared, unwritten pixels are
// undefined
// ----------------------------------------------------------------------------
module framebuffer_scroll_copy import fbsc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input logic          clk,
	input logic          arst_n,
	fbsc_item_if.sink    item,
	fbsc_result_if.source result,
	fbsc_cfg_if.sink     cfg
);

	fbsc_cmd_t  cmd;
	fbsc_stat_t stat;

	// register port never stalls
	assign cfg.ready = 1'b1;

	// sequencer
	fbsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// registers, address arithmetic and frame store
	fbsc_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.action      (item.action),
		.pixel_x     (item.pixel_x),
		.pixel_y     (item.pixel_y),
		.pixel_value (item.pixel_value),
		.shift_down  (item.shift_down),
		.shift_right (item.shift_right),
		.cmd         (cmd),
		.stat        (stat),
		.read_value  (result.read_value),
		.status      (result.status)
	);

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the frame store scroller: directed corner items at
// the frame and size extremes, random pixel writes, reads and scrolls on small
// frames, a receiver hold-off, and a bit-true model predicting every result word
// ----------------------------------------------------------------------------
module tb_top;
	import fbsc_pkg::*;

	localparam int WATCHDOG_LIMIT = 270000; // four full 256x256 scrolls without a word
	localparam int HOLD_CYCLES    = 96;     // long receiver hold-off
	localparam int SETTLE_CYCLES  = 8;      // quiet gap before register writes
	localparam int END_CYCLES     = 16;     // watch for stray words at the end
	localparam int STORE_WORDS    = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

	typedef struct {
		action_t                   act;
		logic [COORD_W-1:0]        px;
		logic [COORD_W-1:0]        py;
		logic [VALUE_W-1:0]        val;
		logic signed [SHIFT_W-1:0] dy;
		logic signed [SHIFT_W-1:0] dx;
	} pix_op_t;

	typedef struct {
		logic [VALUE_W-1:0] rd;
		status_t            st;
	} pix_reply_t;

	logic clk = 1'b0;
	logic arst_n;

	fbsc_item_if   item_ch ();
	fbsc_result_if res_ch ();
	fbsc_cfg_if    cfg_ch ();

	framebuffer_scroll_copy u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// frame model: store contents, which entries hold a written word, active size
	logic [VALUE_W-1:0] frame_mem [STORE_WORDS];
	bit                 frame_set [STORE_WORDS];
	int                 frame_w = DEF_MAX_WIDTH;
	int                 frame_h = DEF_MAX_HEIGHT;

	pix_reply_t pending_replies [$];

	// shared controls between the stimulus and the receiver
	bit calm      = 1'b0; // closing stretch, no idling on either side
	bit tx_jitter = 1'b1; // sender may insert gaps
	bit hold_req  = 1'b0; // ask the receiver for one long hold-off

	int err_cnt   = 0;
	int n_items   = 0;
	int n_scrolls = 0;
	int n_reads   = 0;
	int n_replies = 0;
	int n_frames  = 0;
	int idle_cnt  = 0;

	// register value as the block sees it: zero reads as one, too large saturates
	function automatic int fit_dim(input logic [DIM_W-1:0] v, input int maxv);
		if (v == '0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	// expected word for one accepted item, updating the frame model
	function automatic pix_reply_t predict_frame_op(input pix_op_t op);
		pix_reply_t r;
		int dx, dy, total, i, idx, x, y, sx, sy, src;
		bit fwd;
		r.rd = '0;
		r.st = ST_DONE;
		dx = op.dx;
		dy = op.dy;
		case (op.act)
			ACT_WRITE, ACT_READ: begin
				if (int'(op.px) >= frame_w || int'(op.py) >= frame_h) begin
					r.st = ST_RANGE;
				end else begin
					idx = int'(op.py) * frame_w + int'(op.px);
					if (op.act == ACT_WRITE) begin
						frame_mem[idx] = op.val;
						frame_set[idx] = 1'b1;
					end else begin
						if (!frame_set[idx]) begin
							$error("stimulus reads pixel %0d,%0d before any write", op.px, op.py);
							err_cnt++;
						end
						r.rd = frame_mem[idx];
					end
				end
			end
			ACT_SCROLL: begin
				if (dx == 0 && dy == 0) begin
					r.st = ST_ZERO;
				end else if ((dx < 0 ? -dx : dx) >= frame_w || (dy < 0 ? -dy : dy) >= frame_h) begin
					r.st = ST_RANGE;
				end else begin
					// walk away from the overlap so no source is clobbered first
					total = frame_w * frame_h;
					fwd   = (dy < 0) || (dy == 0 && dx < 0);
					for (i = 0; i < total; i++) begin
						idx = fwd ? i : total - 1 - i;
						x   = idx % frame_w;
						y   = idx / frame_w;
						sx  = x - dx;
						sy  = y - dy;
						if (sx >= 0 && sy >= 0 && sx < frame_w && sy < frame_h) begin
							src = sy * frame_w + sx;
							if (!frame_set[src]) begin
								$error("stimulus scrolls from unwritten pixel %0d,%0d", sx, sy);
								err_cnt++;
							end
							frame_mem[idx] = frame_mem[src];
							frame_set[idx] = 1'b1;
						end
					end
				end
			end
			default: ; // unused action: nothing happens
		endcase
		return r;
	endfunction

	function automatic int rand_shift();
		return int'($urandom_range(0, 510)) - 255;
	endfunction

	// mostly inside the active frame, sometimes anywhere in the 8-bit range
	function automatic int rand_coord(input int limit);
		if ($urandom_range(0, 4) == 0)
			return int'($urandom_range(0, 255));
		return int'($urandom_range(0, limit - 1));
	endfunction

	// mostly a legal offset, some zeros, some anywhere in +/-255
	function automatic int rand_offset(input int limit);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return int'($urandom_range(0, 2 * (limit - 1))) - (limit - 1);
		if (pick == 7)
			return 0;
		return rand_shift();
	endfunction

	// fields an action ignores still get random content
	function automatic pix_op_t make_op(input action_t act, input int x, input int y,
		input logic [VALUE_W-1:0] v, input int dy, input int dx);
		pix_op_t op;
		op.act = act;
		op.px  = COORD_W'($urandom);
		op.py  = COORD_W'($urandom);
		op.val = $urandom;
		op.dy  = SHIFT_W'(rand_shift());
		op.dx  = SHIFT_W'(rand_shift());
		if (act == ACT_WRITE || act == ACT_READ) begin
			op.px = COORD_W'(x);
			op.py = COORD_W'(y);
		end
		if (act == ACT_WRITE)
			op.val = v;
		if (act == ACT_SCROLL) begin
			op.dy = SHIFT_W'(dy);
			op.dx = SHIFT_W'(dx);
		end
		return op;
	endfunction

	// offer one item word, keep valid high afterwards for a back-to-back follower
	task automatic send_op(input pix_op_t op);
		if (tx_jitter && !calm && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.action      <= op.act;
		item_ch.pixel_x     <= op.px;
		item_ch.pixel_y     <= op.py;
		item_ch.pixel_value <= op.val;
		item_ch.shift_down  <= op.dy;
		item_ch.shift_right <= op.dx;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		pending_replies.push_back(predict_frame_op(op));
		n_items++;
		if (op.act == ACT_SCROLL)
			n_scrolls++;
		if (op.act == ACT_READ)
			n_reads++;
	endtask

	// stop offering and wait for every owed result word
	task automatic wait_all_replies();
		item_ch.valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// register writes only once the block has gone quiet
	task automatic set_frame(input int w, input int h);
		wait_all_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int r = 0; r < 2; r++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= (r == 0) ? CFG_WIDTH : CFG_HEIGHT;
			cfg_ch.data  <= DIM_W'((r == 0) ? w : h);
			do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		end
		cfg_ch.valid <= 1'b0;
		frame_w = fit_dim(DIM_W'(w), DEF_MAX_WIDTH);
		frame_h = fit_dim(DIM_W'(h), DEF_MAX_HEIGHT);
		n_frames++;
	endtask

	// full 256x256 frame from reset: value extremes, zero move, unused action,
	// and corner-to-corner scrolls with a single source pixel
	task automatic test_reset_frame();
		send_op(make_op(ACT_WRITE, 0, 0, 32'hA5A5_5A5A, 0, 0));
		send_op(make_op(ACT_WRITE, 255, 255, 32'hFFFF_FFFF, 0, 0));
		send_op(make_op(ACT_WRITE, 255, 0, 32'h0000_0000, 0, 0));
		send_op(make_op(ACT_READ, 255, 255, '0, 0, 0));
		send_op(make_op(ACT_READ, 255, 0, '0, 0, 0));
		send_op(make_op(ACT_SCROLL, 0, 0, '0, 0, 0));
		send_op(make_op(ACT_NONE, 0, 0, '0, 0, 0));
		send_op(make_op(ACT_SCROLL, 0, 0, '0, 255, 255));
		send_op(make_op(ACT_READ, 255, 255, '0, 0, 0));
		send_op(make_op(ACT_SCROLL, 0, 0, '0, -255, -255));
		send_op(make_op(ACT_READ, 0, 0, '0, 0, 0));
	endtask

	// register clamping and range checks at the size extremes
	task automatic test_clamped_dims();
		// zero width and height read as a 1x1 frame
		set_frame(0, 0);
		send_op(make_op(ACT_READ, 0, 0, '0, 0, 0));
		send_op(make_op(ACT_WRITE, 1, 0, 32'h1234_5678, 0, 0));
		send_op(make_op(ACT_READ, 0, 1, '0, 0, 0));
		send_op(make_op(ACT_SCROLL, 0, 0, '0, 1, 0));
		send_op(make_op(ACT_SCROLL, 0, 0, '0, 0, -1));
		send_op(make_op(ACT_WRITE, 0, 0, 32'h8000_0001, 0, 0));
		// oversized width saturates at 256, three rows
		set_frame(511, 3);
		send_op(make_op(ACT_SCROLL, 0, 0, '0, 2, 255));
		send_op(make_op(ACT_READ, 255, 2, '0, 0, 0));
		send_op(make_op(ACT_READ, 0, 3, '0, 0, 0));
		send_op(make_op(ACT_SCROLL, 0, 0, '0, -3, 0));
		// two columns, oversized height saturates at 256
		set_frame(2, 511);
		send_op(make_op(ACT_SCROLL, 0, 0, '0, 255, 1));
		send_op(make_op(ACT_READ, 1, 255, '0, 0, 0));
		send_op(make_op(ACT_SCROLL, 0, 0, '0, -255, -1));
		send_op(make_op(ACT_READ, 0, 0, '0, 0, 0));
	endtask

	// random small frame: fill what is unwritten, then mixed traffic
	task automatic test_random_frame(input int max_w, input int max_h, input int n_ops);
		int w, h, x, y, k, pick;
		w = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, max_w);
		h = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, max_h);
		set_frame(w, h);
		tx_jitter = ($urandom_range(0, 3) != 0);
		for (y = 0; y < frame_h; y++)
			for (x = 0; x < frame_w; x++)
				if (!frame_set[y * frame_w + x])
					send_op(make_op(ACT_WRITE, x, y, $urandom, 0, 0));
		for (k = 0; k < n_ops; k++) begin
			pick = $urandom_range(0, 19);
			if (pick < 6)
				send_op(make_op(ACT_WRITE, rand_coord(frame_w), rand_coord(frame_h),
					$urandom, 0, 0));
			else if (pick < 12)
				send_op(make_op(ACT_READ, rand_coord(frame_w), rand_coord(frame_h),
					'0, 0, 0));
			else if (pick < 19)
				send_op(make_op(ACT_SCROLL, 0, 0, '0, rand_offset(frame_h),
					rand_offset(frame_w)));
			else
				send_op(make_op(ACT_NONE, 0, 0, '0, 0, 0));
		end
	endtask

	// receiver holds off while words keep coming, so the block stalls its input
	task automatic test_backpressure();
		int k;
		bit saved;
		saved     = tx_jitter;
		tx_jitter = 1'b0;
		hold_req  = 1'b1;
		for (k = 0; k < 12; k++)
			send_op(make_op((k % 2 == 0) ? ACT_WRITE : ACT_READ, rand_coord(frame_w),
				rand_coord(frame_h), $urandom, 0, 0));
		// sender pauses here until every owed word is back
		wait_all_replies();
		tx_jitter = saved;
	endtask

	// result side: random stall bursts in random stretches, one long hold-off on request
	initial begin : reply_sink
		int hold_n, mode_left;
		bit rx_jitter;
		res_ch.ready <= 1'b0;
		mode_left = 0;
		rx_jitter = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				rx_jitter = $urandom_range(0, 1);
				mode_left = $urandom_range(32, 96);
			end else begin
				mode_left--;
			end
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				for (hold_n = 0; hold_n < HOLD_CYCLES; hold_n++)
					@(posedge clk);
				hold_req = 1'b0;
				res_ch.ready <= 1'b1;
			end else if (rx_jitter && !calm && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// every result word against the oldest owed word
	always @(posedge clk) begin : reply_check
		pix_reply_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			n_replies++;
			if (pending_replies.size() == 0) begin
				$error("result word with nothing owed: read_value %h status %0d",
					res_ch.read_value, res_ch.status);
				err_cnt++;
			end else begin
				want = pending_replies.pop_front();
				if (res_ch.read_value !== want.rd) begin
					$error("read_value: expected %h, got %h", want.rd, res_ch.read_value);
					err_cnt++;
				end
				if (res_ch.status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, res_ch.status);
					err_cnt++;
				end
			end
		end
	end

	// watchdog: too long without any word moving on any channel
	always @(posedge clk) begin
		if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
			(res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
			(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d still owed",
				idle_cnt, pending_replies.size());
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin : main_seq
		arst_n              <= 1'b0;
		item_ch.valid       <= 1'b0;
		item_ch.action      <= ACT_NONE;
		item_ch.pixel_x     <= '0;
		item_ch.pixel_y     <= '0;
		item_ch.pixel_value <= '0;
		item_ch.shift_down  <= '0;
		item_ch.shift_right <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= CFG_WIDTH;
		cfg_ch.data         <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_frame();
		test_clamped_dims();
		test_random_frame(6, 6, 15);
		test_backpressure();
		test_random_frame(12, 3, 15);
		test_random_frame(3, 12, 15);
		// closing stretch runs flat out
		calm = 1'b1;
		test_random_frame(5, 5, 15);

		wait_all_replies();
		repeat (END_CYCLES) @(posedge clk);

		$display("run covered %0d items (%0d scrolls, %0d pixel reads) over %0d frame sizes",
			n_items, n_scrolls, n_reads, n_frames + 1);
		$display("%0d result words checked, %0d mismatches", n_replies, err_cnt);
		if (err_cnt == 0 && pending_replies.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/fbsc_pkg.sv
rtl/fbsc_if.sv
rtl/fbsc_ram.sv
rtl/fbsc_ctrl.sv
rtl/fbsc_dp.sv
rtl/framebuffer_scroll_copy.sv
tb/tb_top.sv
